FILE: src/psl_pkg.sv
`default_nettype none

package psl_pkg;

  localparam int unsigned DefaultDepth = 16;

  localparam int unsigned PriWidth    = 8;
  localparam int unsigned PidWidth    = 8;
  localparam int unsigned BurstWidth  = 8;
  localparam int unsigned ArriveWidth = 16;
  localparam int unsigned PosWidth    = 4;
  localparam int unsigned CountWidth  = 5;

  // One stored process entry (41 bits).
  typedef struct packed {
    logic [PriWidth-1:0]    pri;
    logic [PidWidth-1:0]    pid;
    logic [BurstWidth-1:0]  burst;
    logic                   io;
    logic [ArriveWidth-1:0] arrive;
  } entry_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_NO_REMOVE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_PUT,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [1:0] op;
    entry_t     ent;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic [PosWidth-1:0]  pos;
    entry_t               ent;
  } res_t;

endpackage

`default_nettype wire

FILE: src/psl_if.sv
`default_nettype none

interface psl_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [psl_pkg::PriWidth-1:0]    priority_req;
  logic [psl_pkg::PidWidth-1:0]    proc_id;
  logic [psl_pkg::BurstWidth-1:0]  burst_length;
  logic                            io_flag;
  logic [psl_pkg::ArriveWidth-1:0] arrival_time;

  modport source (
    output valid, opcode, priority_req, proc_id, burst_length, io_flag, arrival_time,
    input  ready
  );
  modport sink (
    input  valid, opcode, priority_req, proc_id, burst_length, io_flag, arrival_time,
    output ready
  );
endinterface

interface psl_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [psl_pkg::PosWidth-1:0]    position;
  logic [psl_pkg::PriWidth-1:0]    out_priority;
  logic [psl_pkg::PidWidth-1:0]    out_proc_id;
  logic [psl_pkg::BurstWidth-1:0]  out_burst_length;
  logic                            out_io_flag;
  logic [psl_pkg::ArriveWidth-1:0] out_arrival_time;
  logic [psl_pkg::CountWidth-1:0]  entry_count;

  modport source (
    output valid, status, position, out_priority, out_proc_id, out_burst_length,
           out_io_flag, out_arrival_time, entry_count,
    input  ready
  );
  modport sink (
    input  valid, status, position, out_priority, out_proc_id, out_burst_length,
           out_io_flag, out_arrival_time, entry_count,
    output ready
  );
endinterface

`default_nettype wire

FILE: src/priority_sorted_list.sv
`default_nettype none

// Sorted process list: holds up to DEPTH process entries in ascending priority
// order in one synchronous memory (one write and one registered read per cycle).
// Each request gives exactly one response. An insert walks down from the tail,
// moving every entry with priority at or above the new one a slot back, so among
// equal priorities the newest lands first. Into an empty list the entry goes
// straight to the head, and a full list is refused; neither walks.
// A search walks up from the head, reading entries up to the first match. A
// remove-before walks up the same way, then closes the gap one entry a cycle.
// The response then sits in an output register until taken; the next request
// is taken once it has gone. Each walk step reads and writes at most one entry.
// The memory needs no clearing after reset: only entries below the count are
// ever used.
module priority_sorted_list #(
  parameter int unsigned DEPTH = psl_pkg::DefaultDepth
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  psl_req_if.sink     req_i,
  psl_rsp_if.source   rsp_o
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  psl_pkg::state_e state_q, state_d;
  logic [CW-1:0]   total_q, total_d;
  logic [IW-1:0]   rd_addr_q, rd_addr_d;
  psl_pkg::entry_t prev_q, prev_d;
  psl_pkg::req_t   req_q, req_d;
  psl_pkg::res_t   res_q, res_d;

  // Entry memory
  psl_pkg::entry_t mem_q [DEPTH];
  psl_pkg::entry_t rdata_q;
  logic            mem_we;
  logic [IW-1:0]   mem_waddr;
  psl_pkg::entry_t mem_wdata;

  psl_pkg::entry_t new_ent;
  logic [CW-1:0]   nxt_idx;
  logic            nxt_in_range;
  logic [IW-1:0]   up_addr;
  logic [IW-1:0]   dn_addr;

  assign new_ent.pri    = req_i.priority_req;
  assign new_ent.pid    = req_i.proc_id;
  assign new_ent.burst  = req_i.burst_length;
  assign new_ent.io     = req_i.io_flag;
  assign new_ent.arrive = req_i.arrival_time;

  // Neighbors of the entry whose data is in rdata_q
  assign nxt_idx      = CW'(rd_addr_q) + CW'(1);
  assign nxt_in_range = (nxt_idx < total_q);
  assign up_addr      = rd_addr_q + IW'(1);
  assign dn_addr      = rd_addr_q - IW'(1);

  assign req_i.ready = (state_q == psl_pkg::S_IDLE);
  assign rsp_o.valid = (state_q == psl_pkg::S_RESP);

  assign rsp_o.status           = res_q.status;
  assign rsp_o.position         = res_q.pos;
  assign rsp_o.out_priority     = res_q.ent.pri;
  assign rsp_o.out_proc_id      = res_q.ent.pid;
  assign rsp_o.out_burst_length = res_q.ent.burst;
  assign rsp_o.out_io_flag      = res_q.ent.io;
  assign rsp_o.out_arrival_time = res_q.ent.arrive;
  assign rsp_o.entry_count      = psl_pkg::CountWidth'(total_q);

  always_comb begin
    state_d   = state_q;
    total_d   = total_q;
    rd_addr_d = rd_addr_q;
    prev_d    = prev_q;
    req_d     = req_q;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_waddr = up_addr;
    mem_wdata = rdata_q;

    unique case (state_q)
      psl_pkg::S_IDLE: begin
        if (req_i.valid) begin
          req_d.op     = req_i.opcode;
          req_d.ent    = new_ent;
          res_d.status = psl_pkg::ST_OK;
          res_d.pos    = '0;
          res_d.ent    = '0;
          state_d      = psl_pkg::S_RESP;
          case (req_i.opcode)
            psl_pkg::OP_INSERT: begin
              if (total_q == CW'(DEPTH)) begin
                res_d.status = psl_pkg::ST_FULL;
              end else if (total_q == '0) begin
                // Empty list: store at the head right away
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = new_ent;
                total_d   = total_q + CW'(1);
              end else begin
                // Start at the tail
                rd_addr_d = IW'(total_q - CW'(1));
                state_d   = psl_pkg::S_INS;
              end
            end
            psl_pkg::OP_SEARCH, psl_pkg::OP_REMOVE: begin
              if (total_q == '0) begin
                res_d.status = (req_i.opcode == psl_pkg::OP_SEARCH) ?
                               psl_pkg::ST_NOT_FOUND : psl_pkg::ST_NO_REMOVE;
              end else begin
                rd_addr_d = '0;
                state_d   = psl_pkg::S_SCAN;
              end
            end
            default: ;  // no operation: answer with the current count
          endcase
        end
      end

      psl_pkg::S_INS: begin
        mem_we    = 1'b1;
        mem_waddr = up_addr;
        if (rdata_q.pri < req_q.ent.pri) begin
          // Drop the new entry just behind this one
          mem_wdata = req_q.ent;
          res_d.pos = psl_pkg::PosWidth'(up_addr);
          total_d   = total_q + CW'(1);
          state_d   = psl_pkg::S_RESP;
        end else begin
          // Move this entry one slot back and keep walking toward the head
          mem_wdata = rdata_q;
          if (rd_addr_q == '0) begin
            state_d = psl_pkg::S_INS_PUT;
          end else begin
            rd_addr_d = dn_addr;
          end
        end
      end

      psl_pkg::S_INS_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = req_q.ent;
        res_d.pos = '0;
        total_d   = total_q + CW'(1);
        state_d   = psl_pkg::S_RESP;
      end

      psl_pkg::S_SCAN: begin
        if (rdata_q.pri == req_q.ent.pri) begin
          if (req_q.op == psl_pkg::OP_SEARCH) begin
            res_d.ent = rdata_q;
            res_d.pos = psl_pkg::PosWidth'(rd_addr_q);
            state_d   = psl_pkg::S_RESP;
          end else if (rd_addr_q == '0) begin
            res_d.status = psl_pkg::ST_NO_REMOVE;
            state_d      = psl_pkg::S_RESP;
          end else begin
            // Report the entry ahead of the match, then overwrite it
            res_d.ent = prev_q;
            res_d.pos = psl_pkg::PosWidth'(dn_addr);
            mem_we    = 1'b1;
            mem_waddr = dn_addr;
            mem_wdata = rdata_q;
            if (nxt_in_range) begin
              rd_addr_d = IW'(nxt_idx);
              state_d   = psl_pkg::S_SHIFT;
            end else begin
              total_d = total_q - CW'(1);
              state_d = psl_pkg::S_RESP;
            end
          end
        end else begin
          prev_d = rdata_q;
          if (nxt_in_range) begin
            rd_addr_d = IW'(nxt_idx);
          end else begin
            res_d.status = (req_q.op == psl_pkg::OP_SEARCH) ?
                           psl_pkg::ST_NOT_FOUND : psl_pkg::ST_NO_REMOVE;
            state_d      = psl_pkg::S_RESP;
          end
        end
      end

      psl_pkg::S_SHIFT: begin
        // Close the gap: move this entry one slot forward
        mem_we    = 1'b1;
        mem_waddr = dn_addr;
        mem_wdata = rdata_q;
        if (nxt_in_range) begin
          rd_addr_d = IW'(nxt_idx);
        end else begin
          total_d = total_q - CW'(1);
          state_d = psl_pkg::S_RESP;
        end
      end

      psl_pkg::S_RESP: begin
        if (rsp_o.ready) begin
          state_d = psl_pkg::S_IDLE;
        end
      end

      default: state_d = psl_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= psl_pkg::S_IDLE;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q <= rd_addr_d;
    prev_q    <= prev_d;
    req_q     <= req_d;
    res_q     <= res_d;
  end

  // Read the address of the next cycle's walk step; write back in the same cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[rd_addr_d];
  end

endmodule

`default_nettype wire
